// ===== rtl/tbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared sizes, counter constants and types for the tournament predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int ADDR_BITS    = 12;
  localparam int INDEX_BITS   = 12;
  localparam int HISTORY_BITS = 12;
  localparam int COUNT_BITS   = 32;
  localparam int TABLE_DEPTH  = 1 << INDEX_BITS;

  // common width wide enough for address, index and history
  localparam int WIDE_A    = (ADDR_BITS > INDEX_BITS) ? ADDR_BITS : INDEX_BITS;
  localparam int WIDE_BITS = (WIDE_A > HISTORY_BITS) ? WIDE_A : HISTORY_BITS;

  localparam int GSH_BITS = 2;
  localparam int BIM_BITS = 3;
  localparam int CHO_BITS = 2;
  localparam int BC_BITS  = BIM_BITS + CHO_BITS;

  localparam int IN_FIELD_BITS  = ADDR_BITS + 1;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 + 2 * COUNT_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [GSH_BITS-1:0] GSH_MAX   = 2'd3;
  localparam logic [GSH_BITS-1:0] GSH_MIN   = 2'd0;
  localparam logic [GSH_BITS-1:0] GSH_TAKEN = 2'd2;
  localparam logic [GSH_BITS-1:0] GSH_RESET = 2'd0;

  localparam logic [BIM_BITS-1:0] BIM_MIN       = 3'd1;
  localparam logic [BIM_BITS-1:0] BIM_MAX       = 3'd6;
  localparam logic [BIM_BITS-1:0] BIM_TAKEN_MAX = 3'd3;
  localparam logic [BIM_BITS-1:0] BIM_SKIP_FROM = 3'd2;
  localparam logic [BIM_BITS-1:0] BIM_SKIP_TO   = 3'd4;
  localparam logic [BIM_BITS-1:0] BIM_RESET     = 3'd6;

  localparam logic [CHO_BITS-1:0] CHO_MIN   = 2'd0;
  localparam logic [CHO_BITS-1:0] CHO_MAX   = 2'd3;
  localparam logic [CHO_BITS-1:0] CHO_BIM   = 2'd2;
  localparam logic [CHO_BITS-1:0] CHO_RESET = 2'd3;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic                gpred;
    logic                bpred;
    logic                fpred;
    logic                ok;
    logic [GSH_BITS-1:0] g_next;
    logic [BIM_BITS-1:0] b_next;
    logic [CHO_BITS-1:0] c_next;
  } tbp_upd_t;

endpackage

// ===== rtl/tbp_ram.sv =====
// ----------------------------------------------------------------------------
// tbp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // data held when no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tbp_update.sv =====
// ----------------------------------------------------------------------------
// tbp_update
// Prediction and next counter values for one branch.
// ----------------------------------------------------------------------------
module tbp_update (
  input  logic [tbp_pkg::GSH_BITS-1:0] g_ctr,
  input  logic [tbp_pkg::BIM_BITS-1:0] b_ctr,
  input  logic [tbp_pkg::CHO_BITS-1:0] c_ctr,
  input  logic                         taken,
  output tbp_pkg::tbp_upd_t            upd
);
  import tbp_pkg::*;

  always_comb begin
    upd.gpred = (g_ctr >= GSH_TAKEN);
    upd.bpred = (b_ctr <= BIM_TAKEN_MAX);
    upd.fpred = (c_ctr >= CHO_BIM) ? upd.bpred : upd.gpred;
    upd.ok    = (upd.fpred == taken);

    if (taken) begin
      upd.g_next = (g_ctr < GSH_MAX) ? g_ctr + 2'd1 : g_ctr;
      upd.b_next = (b_ctr > BIM_MIN) ? b_ctr - 3'd1 : b_ctr;
    end else begin
      upd.g_next = (g_ctr > GSH_MIN) ? g_ctr - 2'd1 : g_ctr;
      if (b_ctr == BIM_SKIP_FROM) begin
        upd.b_next = BIM_SKIP_TO;
      end else if (b_ctr < BIM_MAX) begin
        upd.b_next = b_ctr + 3'd1;
      end else begin
        upd.b_next = b_ctr;
      end
    end

    // chooser only trains when the two predictors disagree
    upd.c_next = c_ctr;
    if (upd.gpred != upd.bpred) begin
      if (upd.gpred == taken) begin
        upd.c_next = (c_ctr > CHO_MIN) ? c_ctr - 2'd1 : c_ctr;
      end else begin
        upd.c_next = (c_ctr < CHO_MAX) ? c_ctr + 2'd1 : c_ctr;
      end
    end
  end

endmodule

// ===== rtl/tournament_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// tournament_branch_predictor: gshare/bimodal predictor with per-address chooser
// Each request goes through the table read, then the update and output register.
// One request per cycle while m_tready does not hold the output; forwarding covers back-to-back same entry.
// After reset the tables are swept with s_tready low.
// ----------------------------------------------------------------------------
module tournament_branch_predictor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [11:0] branch_address, [12] actual_taken
  input  logic [tbp_pkg::IN_DATA_BITS-1:0]  s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] predicted_taken, [1] was_correct, [33:2] correct_total, [65:34] branch_total
  output logic [tbp_pkg::OUT_DATA_BITS-1:0] m_tdata
);
  import tbp_pkg::*;

  localparam idx_t IDX_LAST = '1;

  // clearing sweep
  logic clearing;
  idx_t clear_idx;

  // request decode
  logic                    accept;
  logic [ADDR_BITS-1:0]    in_addr;
  logic                    in_taken;
  logic [WIDE_BITS-1:0]    addr_w;
  logic [WIDE_BITS-1:0]    gidx_w;
  idx_t                    in_bidx;
  idx_t                    in_gidx;
  logic [HISTORY_BITS-1:0] hist;

  // table stage
  logic s1_valid;
  logic s1_fire;
  idx_t s1_bidx;
  idx_t s1_gidx;
  logic s1_taken;

  logic [GSH_BITS-1:0] g_rdata;
  logic [BC_BITS-1:0]  bc_rdata;
  logic [GSH_BITS-1:0] g_ctr;
  logic [BC_BITS-1:0]  bc_ctr;

  // last write of each table, for forwarding
  logic                fwd_g_valid;
  idx_t                fwd_g_idx;
  logic [GSH_BITS-1:0] fwd_g_data;
  logic                fwd_bc_valid;
  idx_t                fwd_bc_idx;
  logic [BC_BITS-1:0]  fwd_bc_data;

  tbp_upd_t upd;

  logic                ram_we;
  idx_t                g_waddr;
  idx_t                bc_waddr;
  logic [GSH_BITS-1:0] g_wdata;
  logic [BC_BITS-1:0]  bc_wdata;

  count_t correct_count;
  count_t branch_count;
  count_t correct_next;
  count_t branch_next;

  // output register
  logic   out_pred;
  logic   out_ok;
  count_t out_correct;
  count_t out_branch;

  assign in_addr  = s_tdata[ADDR_BITS-1:0];
  assign in_taken = s_tdata[ADDR_BITS];
  assign addr_w   = WIDE_BITS'(in_addr);
  assign gidx_w   = addr_w ^ WIDE_BITS'(hist);
  assign in_bidx  = addr_w[INDEX_BITS-1:0];
  assign in_gidx  = gidx_w[INDEX_BITS-1:0];

  assign s1_fire  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !clearing && (!s1_valid || s1_fire);
  assign accept   = s_tvalid && s_tready;

  assign g_ctr  = (fwd_g_valid && fwd_g_idx == s1_gidx) ? fwd_g_data : g_rdata;
  assign bc_ctr = (fwd_bc_valid && fwd_bc_idx == s1_bidx) ? fwd_bc_data : bc_rdata;

  tbp_update u_update (
    .g_ctr (g_ctr),
    .b_ctr (bc_ctr[BIM_BITS-1:0]),
    .c_ctr (bc_ctr[BC_BITS-1:BIM_BITS]),
    .taken (s1_taken),
    .upd   (upd)
  );

  assign ram_we   = clearing || s1_fire;
  assign g_waddr  = clearing ? clear_idx : s1_gidx;
  assign bc_waddr = clearing ? clear_idx : s1_bidx;
  assign g_wdata  = clearing ? GSH_RESET : upd.g_next;
  assign bc_wdata = clearing ? {CHO_RESET, BIM_RESET} : {upd.c_next, upd.b_next};

  tbp_ram #(.WIDTH(GSH_BITS), .DEPTH(TABLE_DEPTH)) u_gshare_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (accept),
    .raddr (in_gidx),
    .rdata (g_rdata)
  );

  // bimodal and chooser share the address index
  tbp_ram #(.WIDTH(BC_BITS), .DEPTH(TABLE_DEPTH)) u_bc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bc_waddr),
    .wdata (bc_wdata),
    .re    (accept),
    .raddr (in_bidx),
    .rdata (bc_rdata)
  );

  assign branch_next  = (branch_count == '1) ? branch_count : branch_count + 1'b1;
  assign correct_next = (upd.ok && correct_count != '1) ? correct_count + 1'b1
                                                        : correct_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clear_idx     <= '0;
      hist          <= '0;
      s1_valid      <= 1'b0;
      fwd_g_valid   <= 1'b0;
      fwd_bc_valid  <= 1'b0;
      correct_count <= '0;
      branch_count  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (clearing) begin
        clear_idx <= clear_idx + 1'b1;
        if (clear_idx == IDX_LAST) begin
          clearing <= 1'b0;
        end
      end

      if (accept) begin
        hist     <= HISTORY_BITS'({hist, in_taken});
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        fwd_g_valid   <= 1'b1;
        fwd_bc_valid  <= 1'b1;
        correct_count <= correct_next;
        branch_count  <= branch_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bidx  <= in_bidx;
      s1_gidx  <= in_gidx;
      s1_taken <= in_taken;
    end
    if (s1_fire) begin
      fwd_g_idx   <= s1_gidx;
      fwd_g_data  <= upd.g_next;
      fwd_bc_idx  <= s1_bidx;
      fwd_bc_data <= {upd.c_next, upd.b_next};
      out_pred    <= upd.fpred;
      out_ok      <= upd.ok;
      out_correct <= correct_next;
      out_branch  <= branch_next;
    end
  end

  assign m_tdata = {(OUT_DATA_BITS - OUT_FIELD_BITS)'(0),
                    out_branch, out_correct, out_ok, out_pred};

`ifndef SYNTHESIS
  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("request taken during table sweep");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |=> s1_valid)
    else $error("table stage dropped a request under back-pressure");

  a_branch_step: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> (branch_count == $past(branch_count) + 1'b1 ||
                 $past(branch_count) == '1))
    else $error("branch total did not advance");

  a_correct_bound: assert property (@(posedge clk) disable iff (rst)
    correct_count <= branch_count)
    else $error("correct total exceeds branch total");
`endif

endmodule

// ===== verif/tournament_branch_predictor_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor_test
// Streams resolved branches into the predictor and checks every result
// against a cycle-free predictor of the gshare/bimodal/chooser tables kept
// here. Runs a directed walk over counter limits, then random loop-like
// branch streams under several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_test;

  localparam int ADDR_W         = 12;
  localparam int TABLE_SIZE     = 1 << ADDR_W;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 12000;
  localparam int SETTLE_CYCLES  = 10;

  localparam logic [1:0] GSH_TOP = 2'd3;
  localparam logic [1:0] GSH_ON  = 2'd2;
  localparam logic [2:0] BIM_LO  = 3'd1;
  localparam logic [2:0] BIM_HI  = 3'd6;
  localparam logic [2:0] BIM_ON  = 3'd3;
  localparam logic [1:0] CHO_TOP = 2'd3;
  localparam logic [1:0] CHO_BIM = 2'd2;
  localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

  typedef enum logic {REQ_BRANCH, REQ_DRAIN} req_kind_t;

  typedef struct {
    req_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic              taken;
  } branch_req_t;

  typedef struct {
    logic        predicted_taken;
    logic        was_correct;
    logic [31:0] correct_total;
    logic [31:0] branch_total;
  } branch_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [tbp_pkg::IN_DATA_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [tbp_pkg::OUT_DATA_BITS-1:0] m_tdata;

  tournament_branch_predictor u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [1:0]        gshare_tab  [TABLE_SIZE];
  logic [2:0]        bimodal_tab [TABLE_SIZE];
  logic [1:0]        chooser_tab [TABLE_SIZE];
  logic [ADDR_W-1:0] history;
  logic [31:0]       correct_count;
  logic [31:0]       branch_count;

  branch_req_t    pending_reqs[$];
  branch_result_t expected_results[$];

  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   hold_reqs     = 0;
  int   holds_done    = 0;
  int   hold_left     = 0;
  int   quiet_cycles  = 0;
  logic req_accepted  = 1'b0;
  logic failed        = 1'b0;

  function automatic branch_result_t predict_branch(logic [ADDR_W-1:0] addr, logic taken);
    logic [ADDR_W-1:0] bidx;
    logic [ADDR_W-1:0] gidx;
    logic              gp;
    logic              bp;
    logic              fp;
    branch_result_t    r;
    bidx = addr;
    gidx = addr ^ history;
    gp = (gshare_tab[gidx] >= GSH_ON);
    bp = (bimodal_tab[bidx] <= BIM_ON);
    fp = (chooser_tab[bidx] >= CHO_BIM) ? bp : gp;
    if (fp == taken && correct_count != TOTAL_MAX) correct_count++;
    if (branch_count != TOTAL_MAX) branch_count++;
    if (taken) begin
      if (gshare_tab[gidx] < GSH_TOP) gshare_tab[gidx]++;
      if (bimodal_tab[bidx] > BIM_LO) bimodal_tab[bidx]--;
    end else begin
      if (gshare_tab[gidx] > 2'd0) gshare_tab[gidx]--;
      // not-taken skips state 3 on the way up
      if (bimodal_tab[bidx] == 3'd2) bimodal_tab[bidx] = 3'd4;
      else if (bimodal_tab[bidx] < BIM_HI) bimodal_tab[bidx]++;
    end
    if (gp != bp) begin
      if (gp == taken) begin
        if (chooser_tab[bidx] > 2'd0) chooser_tab[bidx]--;
      end else if (chooser_tab[bidx] < CHO_TOP) begin
        chooser_tab[bidx]++;
      end
    end
    history = {history[ADDR_W-2:0], taken};
    r.predicted_taken = fp;
    r.was_correct     = (fp == taken);
    r.correct_total   = correct_count;
    r.branch_total    = branch_count;
    return r;
  endfunction

  // request driver
  always @(negedge clk) begin : driver
    branch_req_t                      req;
    logic [tbp_pkg::IN_DATA_BITS-1:0] word;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_accepted) begin
      if (pending_reqs.size() == 0 || $urandom_range(99) < send_idle_pct) begin
        s_tvalid <= 1'b0;
      end else if (pending_reqs[0].kind == REQ_DRAIN) begin
        // hold off until every outstanding result is back
        s_tvalid <= 1'b0;
        if (expected_results.size() == 0) void'(pending_reqs.pop_front());
      end else begin
        req = pending_reqs.pop_front();
        word = '0;
        word[ADDR_W-1:0] = req.addr;
        word[ADDR_W] = req.taken;
        s_tvalid <= 1'b1;
        s_tdata <= word;
      end
    end
  end

  // result sink
  always @(negedge clk) begin : sink
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_reqs) begin
      m_tready <= 1'b0;
      holds_done <= holds_done + 1;
      hold_left <= LONG_HOLD;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    branch_result_t want;
    branch_result_t got;
    branch_result_t pred;
    req_accepted <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      pred = predict_branch(s_tdata[ADDR_W-1:0], s_tdata[ADDR_W]);
      expected_results = {expected_results, pred};
    end
    if (!rst && m_tvalid && m_tready) begin
      got.predicted_taken = m_tdata[0];
      got.was_correct     = m_tdata[1];
      got.correct_total   = m_tdata[33:2];
      got.branch_total    = m_tdata[65:34];
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, m_tdata);
        failed <= 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (got.predicted_taken !== want.predicted_taken) begin
          $display("%0t: predicted_taken exp %0b got %0b", $time,
                   want.predicted_taken, got.predicted_taken);
          failed <= 1'b1;
        end
        if (got.was_correct !== want.was_correct) begin
          $display("%0t: was_correct exp %0b got %0b", $time,
                   want.was_correct, got.was_correct);
          failed <= 1'b1;
        end
        if (got.correct_total !== want.correct_total) begin
          $display("%0t: correct_total exp %0d got %0d", $time,
                   want.correct_total, got.correct_total);
          failed <= 1'b1;
        end
        if (got.branch_total !== want.branch_total) begin
          $display("%0t: branch_total exp %0d got %0d", $time,
                   want.branch_total, got.branch_total);
          failed <= 1'b1;
        end
      end
    end
  end

  // table sweep after reset keeps s_tready low before any traffic
  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_branch(logic [ADDR_W-1:0] addr, logic taken);
    branch_req_t req;
    req.kind  = REQ_BRANCH;
    req.addr  = addr;
    req.taken = taken;
    pending_reqs = {pending_reqs, req};
  endtask

  task automatic add_drain();
    branch_req_t req;
    req.kind  = REQ_DRAIN;
    req.addr  = '0;
    req.taken = 1'b0;
    pending_reqs = {pending_reqs, req};
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_results.size() != 0 || s_tvalid)
      @(negedge clk);
  endtask

  // mostly loop-like branches from a small working set, some noise
  task automatic add_random_stream(int count);
    logic [ADDR_W-1:0] pool   [8];
    int                period [8];
    int                iter   [8];
    int                j;
    int                r;
    for (int k = 0; k < 8; k++) begin
      pool[k]   = ADDR_W'($urandom_range(TABLE_SIZE - 1));
      period[k] = $urandom_range(2, 9);
      iter[k]   = 0;
    end
    pool[0] = '0;
    pool[1] = '1;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) add_drain();
      r = $urandom_range(99);
      j = $urandom_range(7);
      if (r < 75) begin
        add_branch(pool[j], (iter[j] % period[j]) != period[j] - 1);
        iter[j]++;
      end else if (r < 90) begin
        add_branch(pool[j], 1'($urandom_range(1)));
      end else begin
        add_branch(ADDR_W'($urandom_range(TABLE_SIZE - 1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < TABLE_SIZE; i++) begin
      gshare_tab[i]  = 2'd0;
      bimodal_tab[i] = BIM_HI;
      chooser_tab[i] = CHO_TOP;
    end
    history       = '0;
    correct_count = '0;
    branch_count  = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: counter floors, ceilings and the bimodal jump from 2 to 4
    repeat (4) add_branch(12'h000, 1'b0);
    repeat (6) add_branch(12'h000, 1'b1);
    repeat (3) add_branch(12'h000, 1'b0);
    repeat (4) add_branch(12'hFFF, 1'b1);
    repeat (2) add_branch(12'hFFF, 1'b0);
    repeat (2) begin
      add_branch(12'h555, 1'b1);
      add_branch(12'hAAA, 1'b0);
    end
    wait_drained();

    // no idling; receiver holds off long enough to back up the pipeline
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_reqs     = hold_reqs + 1;
    add_random_stream(375);
    wait_drained();

    send_idle_pct = 49;
    stall_pct     = 0;
    add_random_stream(375);
    wait_drained();

    send_idle_pct = 0;
    stall_pct     = 49;
    add_random_stream(375);
    wait_drained();

    send_idle_pct = 12;
    stall_pct     = 12;
    add_random_stream(375);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
